### rtl/core/vot_pkg.sv
// ----------------------------------------------------------------------------
// Virtual order queue tracker package
// Shared constants, the table entry layout and the sequencer state types.
// ----------------------------------------------------------------------------
package vot_pkg;

  // Default table size.
  localparam int TABLE_DEPTH_DEF = 64;

  // Command codes.
  localparam logic [2:0] CMD_PLACE   = 3'd0;
  localparam logic [2:0] CMD_CANCEL  = 3'd1;
  localparam logic [2:0] CMD_TRADE   = 3'd2;
  localparam logic [2:0] CMD_MARK    = 3'd3;
  localparam logic [2:0] CMD_COMPACT = 3'd4;

  // Order status codes.
  localparam logic [1:0] STAT_PENDING   = 2'd0;
  localparam logic [1:0] STAT_FILLED    = 2'd1;
  localparam logic [1:0] STAT_CANCELLED = 2'd2;

  // The price scale 1e8 is 2^8 times SCALE_ODD. SCALE_RECIP is
  // floor(2^50 / SCALE_ODD), used to divide by SCALE_ODD with a multiply.
  localparam logic [18:0] SCALE_ODD   = 19'd390625;
  localparam logic [31:0] SCALE_RECIP = 32'd2882303761;

  // One stored order.
  typedef struct packed {
    logic [31:0] id;
    logic        side;
    logic [46:0] price;
    logic [31:0] qty;
    logic [31:0] ahead_qty;
    logic [1:0]  status;
    logic [63:0] profit;
    logic [62:0] fill_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Main sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EVAL,
    S_MWAIT,
    S_FIN
  } state_t;

  // Profit unit states.
  typedef enum logic [3:0] {
    PU_IDLE,
    PU_MLO,
    PU_MHI,
    PU_SUM,
    PU_RLO,
    PU_RHI,
    PU_EST,
    PU_BACK,
    PU_FIX,
    PU_FIN
  } pu_state_t;

endpackage

### rtl/core/vot_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/vot_profit_unit.sv
// ----------------------------------------------------------------------------
// Profit unit
// Computes (a - b) * q / 1e8 truncated toward zero with one 32-bit multiplier
// shared by the product and by a reciprocal division done 32 bits at a time.
// ----------------------------------------------------------------------------
module vot_profit_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [46:0] a,
  input  logic [46:0] b,
  input  logic [31:0] q,
  output logic        done,
  output logic [63:0] result
);

  localparam logic [50:0] D1 = {32'd0, vot_pkg::SCALE_ODD};
  localparam logic [50:0] D2 = {31'd0, vot_pkg::SCALE_ODD, 1'b0};

  vot_pkg::pu_state_t state, state_next;

  logic        neg;
  logic [46:0] mag;
  logic [31:0] qr;
  logic [63:0] p_lo;
  logic [63:0] p_hi;
  logic [63:0] dq;
  logic [26:0] rem;
  logic        limb;
  logic [31:0] q_est;
  logic [63:0] back;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [78:0] sum;
  logic [63:0] est_sum;
  logic [58:0] cur;
  logic [50:0] x;
  logic [50:0] r_raw;
  logic [50:0] r_fix;
  logic [31:0] qd;

  // The upper dividend limb sits in dq[63:32]; the scale's factor 2^8 is a shift.
  assign cur     = {rem, dq[63:32]};
  assign x       = cur[58:8];
  assign sum     = {15'd0, p_lo} + {p_hi[46:0], 32'd0};
  assign est_sum = p_hi + {32'd0, p_lo[63:32]};

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      vot_pkg::PU_MLO: begin
        mul_a = qr;
        mul_b = mag[31:0];
      end
      vot_pkg::PU_MHI: begin
        mul_a = qr;
        mul_b = {17'd0, mag[46:32]};
      end
      vot_pkg::PU_RLO: begin
        mul_a = x[31:0];
        mul_b = vot_pkg::SCALE_RECIP;
      end
      vot_pkg::PU_RHI: begin
        mul_a = {13'd0, x[50:32]};
        mul_b = vot_pkg::SCALE_RECIP;
      end
      vot_pkg::PU_BACK: begin
        mul_a = q_est;
        mul_b = {13'd0, vot_pkg::SCALE_ODD};
      end
      default: begin
      end
    endcase
    mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // The estimate is at most two below the true quotient digit; fix it up.
  always_comb begin
    r_raw = x - back[50:0];
    if (r_raw >= D2) begin
      qd    = q_est + 32'd2;
      r_fix = r_raw - D2;
    end else if (r_raw >= D1) begin
      qd    = q_est + 32'd1;
      r_fix = r_raw - D1;
    end else begin
      qd    = q_est;
      r_fix = r_raw;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      vot_pkg::PU_IDLE: if (start) state_next = vot_pkg::PU_MLO;
      vot_pkg::PU_MLO:  state_next = vot_pkg::PU_MHI;
      vot_pkg::PU_MHI:  state_next = vot_pkg::PU_SUM;
      vot_pkg::PU_SUM:  state_next = vot_pkg::PU_RLO;
      vot_pkg::PU_RLO:  state_next = vot_pkg::PU_RHI;
      vot_pkg::PU_RHI:  state_next = vot_pkg::PU_EST;
      vot_pkg::PU_EST:  state_next = vot_pkg::PU_BACK;
      vot_pkg::PU_BACK: state_next = vot_pkg::PU_FIX;
      vot_pkg::PU_FIX:  state_next = limb ? vot_pkg::PU_FIN : vot_pkg::PU_RLO;
      vot_pkg::PU_FIN:  state_next = vot_pkg::PU_IDLE;
      default:          state_next = vot_pkg::PU_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    done   = (state == vot_pkg::PU_FIN);
    result = neg ? (64'd0 - dq) : dq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vot_pkg::PU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      vot_pkg::PU_IDLE: begin
        neg <= (a < b);
        mag <= (a < b) ? (b - a) : (a - b);
        qr  <= q;
      end
      vot_pkg::PU_MLO: begin
        p_lo <= mul_p;
      end
      vot_pkg::PU_MHI: begin
        p_hi <= mul_p;
      end
      vot_pkg::PU_SUM: begin
        // The top limb is below the scale, so it is the first remainder.
        dq   <= sum[63:0];
        rem  <= {12'd0, sum[78:64]};
        limb <= 1'b0;
      end
      vot_pkg::PU_RLO: begin
        p_lo <= mul_p;
      end
      vot_pkg::PU_RHI: begin
        p_hi <= mul_p;
      end
      vot_pkg::PU_EST: begin
        q_est <= est_sum[49:18];
      end
      vot_pkg::PU_BACK: begin
        back <= mul_p;
      end
      vot_pkg::PU_FIX: begin
        dq   <= {dq[31:0], qd};
        rem  <= {r_fix[18:0], cur[7:0]};
        limb <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/virtual_order_queue_tracker.sv
// ----------------------------------------------------------------------------
// Virtual order queue tracker
// Table of virtual limit orders walked by a small sequencer, one command per
// word, with a shared multiply and divide unit for mark to market.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy stays high
// until the result, which is shown for one cycle with done high and cannot be
// held off by the receiver. The table sits in a single-port-read RAM, so every
// walked entry goes through a read state, then an evaluate and write back
// state. Place scans the valid flags one per cycle. Cancel, trade and compact
// walk the whole table (cancel stops at its match; compact skips the walk when
// age_limit_ns is above now_ns). Mark walks it too and runs each filled entry
// through the shared profit unit (two multiply passes for the product, then
// two reciprocal division steps, each through RLO, RHI, EST, BACK and FIX).
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module virtual_order_queue_tracker #(
  parameter int TABLE_DEPTH = vot_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic        side,
  input  logic [46:0] price_fx,
  input  logic [31:0] quantity,
  input  logic [31:0] resting_ahead,
  input  logic [31:0] target_id,
  input  logic [46:0] micro_price_fx,
  input  logic [62:0] now_ns,
  input  logic [62:0] age_limit_ns,
  output logic        done,
  output logic [31:0] new_id,
  output logic        ok,
  output logic signed [63:0] total_profit
);

  localparam int IW = $clog2(TABLE_DEPTH);

  vot_pkg::state_t state, state_next;

  // Captured command word.
  logic [2:0]  cmd_r;
  logic        side_r;
  logic [46:0] price_r;
  logic [31:0] qty_r;
  logic [31:0] ahead_r;
  logic [31:0] target_r;
  logic [46:0] mark_r;
  logic [62:0] now_r;
  logic [62:0] cutoff;

  logic [IW-1:0]          idx;
  logic                   last;
  logic [TABLE_DEPTH-1:0] valid;
  logic [31:0]            next_order_id;
  logic [63:0]            total;
  logic                   ok_r;
  logic [31:0]            new_id_r;

  vot_pkg::entry_t rdata, ent, wdata;
  logic [vot_pkg::ENTRY_W-1:0] rdata_raw;
  logic            we;

  // Per-entry decisions in the evaluate state.
  logic cancel_hit, trade_hit, mark_hit, compact_hit;
  logic pu_start, pu_done;
  logic [63:0] pu_result;

  assign last  = (idx == IW'(TABLE_DEPTH - 1));
  assign rdata = vot_pkg::entry_t'(rdata_raw);

  assign cancel_hit  = valid[idx] && rdata.id == target_r
                       && rdata.status == vot_pkg::STAT_PENDING;
  assign trade_hit   = valid[idx] && rdata.status == vot_pkg::STAT_PENDING
                       && rdata.price == price_r && rdata.side == side_r;
  assign mark_hit    = valid[idx] && rdata.status == vot_pkg::STAT_FILLED;
  assign compact_hit = valid[idx] && (rdata.status == vot_pkg::STAT_FILLED
                       || rdata.status == vot_pkg::STAT_CANCELLED)
                       && rdata.fill_time < cutoff;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      vot_pkg::S_IDLE: begin
        if (start) begin
          unique case (cmd) inside
            vot_pkg::CMD_PLACE: state_next = vot_pkg::S_SCAN;
            vot_pkg::CMD_CANCEL, vot_pkg::CMD_TRADE, vot_pkg::CMD_MARK:
              state_next = vot_pkg::S_READ;
            vot_pkg::CMD_COMPACT:
              state_next = (age_limit_ns <= now_ns) ? vot_pkg::S_READ : vot_pkg::S_FIN;
            default: state_next = vot_pkg::S_FIN;
          endcase
        end
      end
      vot_pkg::S_SCAN: begin
        if (!valid[idx] || last) state_next = vot_pkg::S_FIN;
      end
      vot_pkg::S_READ: state_next = vot_pkg::S_EVAL;
      vot_pkg::S_EVAL: begin
        if (cmd_r == vot_pkg::CMD_MARK && mark_hit) begin
          state_next = vot_pkg::S_MWAIT;
        end else if (cmd_r == vot_pkg::CMD_CANCEL && cancel_hit) begin
          state_next = vot_pkg::S_FIN;
        end else begin
          state_next = last ? vot_pkg::S_FIN : vot_pkg::S_READ;
        end
      end
      vot_pkg::S_MWAIT: begin
        if (pu_done) state_next = last ? vot_pkg::S_FIN : vot_pkg::S_READ;
      end
      vot_pkg::S_FIN: state_next = vot_pkg::S_IDLE;
      default:        state_next = vot_pkg::S_IDLE;
    endcase
  end

  // Table write and profit unit start.
  always_comb begin
    we       = 1'b0;
    wdata    = rdata;
    pu_start = 1'b0;
    unique case (state)
      vot_pkg::S_SCAN: begin
        we              = !valid[idx];
        wdata.id        = next_order_id;
        wdata.side      = side_r;
        wdata.price     = price_r;
        wdata.qty       = qty_r;
        wdata.ahead_qty = ahead_r;
        wdata.status    = vot_pkg::STAT_PENDING;
        wdata.profit    = '0;
        wdata.fill_time = '0;
      end
      vot_pkg::S_EVAL: begin
        if (cmd_r == vot_pkg::CMD_CANCEL && cancel_hit) begin
          we           = 1'b1;
          wdata.status = vot_pkg::STAT_CANCELLED;
        end else if (cmd_r == vot_pkg::CMD_TRADE && trade_hit) begin
          we = 1'b1;
          if (rdata.ahead_qty != '0) begin
            wdata.ahead_qty = (rdata.ahead_qty > qty_r) ? rdata.ahead_qty - qty_r : '0;
          end else begin
            wdata.status    = vot_pkg::STAT_FILLED;
            wdata.fill_time = now_r;
          end
        end
        pu_start = (cmd_r == vot_pkg::CMD_MARK) && mark_hit;
      end
      vot_pkg::S_MWAIT: begin
        we           = pu_done;
        wdata        = ent;
        wdata.profit = pu_result;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= vot_pkg::S_IDLE;
      valid         <= '0;
      next_order_id <= '0;
      total         <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == vot_pkg::S_FIN);
      // Valid flags, id counter and running profit total.
      if (state == vot_pkg::S_SCAN && !valid[idx]) begin
        valid[idx]    <= 1'b1;
        next_order_id <= next_order_id + 32'd1;
      end
      if (state == vot_pkg::S_EVAL && cmd_r == vot_pkg::CMD_COMPACT && compact_hit) begin
        valid[idx] <= 1'b0;
        total      <= total - rdata.profit;
      end
      if (state == vot_pkg::S_MWAIT && pu_done) begin
        total <= total + pu_result - ent.profit;
      end
    end
  end

  // Command capture, walk index and result fields.
  always_ff @(posedge clk) begin
    if (state == vot_pkg::S_IDLE && start) begin
      cmd_r    <= cmd;
      side_r   <= side;
      price_r  <= price_fx;
      qty_r    <= quantity;
      ahead_r  <= resting_ahead;
      target_r <= target_id;
      mark_r   <= micro_price_fx;
      now_r    <= now_ns;
      cutoff   <= now_ns - age_limit_ns;
      idx      <= '0;
      new_id_r <= '0;
      ok_r     <= !(cmd == vot_pkg::CMD_PLACE || cmd == vot_pkg::CMD_CANCEL);
    end
    if (state == vot_pkg::S_SCAN) begin
      if (!valid[idx]) begin
        new_id_r <= next_order_id;
        ok_r     <= 1'b1;
      end else if (!last) begin
        idx <= idx + IW'(1);
      end
    end
    if (state == vot_pkg::S_EVAL) begin
      ent <= rdata;
      if (cmd_r == vot_pkg::CMD_CANCEL && cancel_hit) begin
        ok_r <= 1'b1;
      end else if (!(cmd_r == vot_pkg::CMD_MARK && mark_hit) && !last) begin
        idx <= idx + IW'(1);
      end
    end
    if (state == vot_pkg::S_MWAIT && pu_done && !last) begin
      idx <= idx + IW'(1);
    end
    if (state == vot_pkg::S_FIN) begin
      new_id       <= new_id_r;
      ok           <= ok_r;
      total_profit <= total;
    end
  end

  assign busy = (state != vot_pkg::S_IDLE);

  vot_ram #(
    .WIDTH(vot_pkg::ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(idx),
    .wdata(wdata),
    .raddr(idx),
    .rdata(rdata_raw)
  );

  // Bid profits on mark minus price, ask on price minus mark.
  vot_profit_unit u_profit (
    .clk   (clk),
    .rst   (rst),
    .start (pu_start),
    .a     (rdata.side ? rdata.price : mark_r),
    .b     (rdata.side ? mark_r : rdata.price),
    .q     (rdata.qty),
    .done  (pu_done),
    .result(pu_result)
  );

endmodule

### bench/tb_virtual_order_queue_tracker.sv
// ----------------------------------------------------------------------------
// Virtual order queue tracker testbench
// Drives command words from a queue, predicts every result with a behavioral
// order table and checks each done word field by field against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_virtual_order_queue_tracker;

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        side;
    logic [46:0] price;
    logic [31:0] qty;
    logic [31:0] ahead;
    logic [31:0] target;
    logic [46:0] mark;
    logic [62:0] now;
    logic [62:0] age;
  } order_cmd_t;

  typedef struct packed {
    logic [31:0] new_id;
    logic        ok;
    logic [63:0] total;
  } order_res_t;

  localparam int CMD_W = $bits(order_cmd_t);

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  cmd;
  logic        side;
  logic [46:0] price_fx;
  logic [31:0] quantity;
  logic [31:0] resting_ahead;
  logic [31:0] target_id;
  logic [46:0] micro_price_fx;
  logic [62:0] now_ns;
  logic [62:0] age_limit_ns;
  logic        done;
  logic [31:0] new_id;
  logic        ok;
  logic signed [63:0] total_profit;

  virtual_order_queue_tracker #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .side(side),
    .price_fx(price_fx), .quantity(quantity), .resting_ahead(resting_ahead),
    .target_id(target_id), .micro_price_fx(micro_price_fx), .now_ns(now_ns),
    .age_limit_ns(age_limit_ns), .done(done), .new_id(new_id), .ok(ok),
    .total_profit(total_profit)
  );

  // Predicted order table.
  logic        tbl_valid [DEPTH];
  logic [31:0] tbl_id    [DEPTH];
  logic        tbl_side  [DEPTH];
  logic [46:0] tbl_price [DEPTH];
  logic [31:0] tbl_qty   [DEPTH];
  logic [31:0] tbl_pos   [DEPTH];
  logic [1:0]  tbl_stat  [DEPTH];
  logic [63:0] tbl_pnl   [DEPTH];
  logic [62:0] tbl_ftime [DEPTH];
  logic [31:0] next_id;

  order_cmd_t pending_cmds[$];
  order_res_t expected_results[$];
  int         errors;
  int         results_seen;
  int         sender_idle_pct;
  int         cmd_count[8];

  // Append one word to the pending queue.
  task automatic add_pending(order_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // Signed profit of one filled order: (hi - lo) * q / 1e8, truncated to zero.
  function automatic logic [63:0] fill_profit(logic [46:0] hi, logic [46:0] lo,
                                              logic [31:0] q);
    logic [47:0]  mag;
    logic [79:0]  prod;
    logic [79:0]  quo;
    mag  = (hi >= lo) ? {1'b0, hi - lo} : {1'b0, lo - hi};
    prod = mag * q;
    quo  = prod / 80'd100000000;
    return (hi >= lo) ? quo[63:0] : -quo[63:0];
  endfunction

  // Apply one command to the predicted table and return its result word.
  function automatic order_res_t apply_order_cmd(order_cmd_t c);
    order_res_t r;
    logic [62:0] cutoff;
    r = '0;
    r.ok = 1'b1;
    case (c.cmd)
      vot_pkg::CMD_PLACE: begin
        r.ok = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
          if (!tbl_valid[i] && !r.ok) begin
            tbl_valid[i] = 1'b1; tbl_id[i] = next_id; tbl_side[i] = c.side;
            tbl_price[i] = c.price; tbl_qty[i] = c.qty; tbl_pos[i] = c.ahead;
            tbl_stat[i] = vot_pkg::STAT_PENDING; tbl_pnl[i] = '0; tbl_ftime[i] = '0;
            r.new_id = next_id;
            next_id++;
            r.ok = 1'b1;
          end
        end
      end
      vot_pkg::CMD_CANCEL: begin
        r.ok = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
          if (!r.ok && tbl_valid[i] && tbl_id[i] == c.target &&
              tbl_stat[i] == vot_pkg::STAT_PENDING) begin
            tbl_stat[i] = vot_pkg::STAT_CANCELLED;
            r.ok = 1'b1;
          end
        end
      end
      vot_pkg::CMD_TRADE: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i] && tbl_stat[i] == vot_pkg::STAT_PENDING &&
              tbl_price[i] == c.price && tbl_side[i] == c.side) begin
            if (tbl_pos[i] != 0) begin
              tbl_pos[i] = (tbl_pos[i] > c.qty) ? tbl_pos[i] - c.qty : '0;
            end else begin
              tbl_stat[i] = vot_pkg::STAT_FILLED;
              tbl_ftime[i] = c.now;
            end
          end
        end
      end
      vot_pkg::CMD_MARK: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i] && tbl_stat[i] == vot_pkg::STAT_FILLED) begin
            tbl_pnl[i] = tbl_side[i] ? fill_profit(tbl_price[i], c.mark, tbl_qty[i])
                                     : fill_profit(c.mark, tbl_price[i], tbl_qty[i]);
          end
        end
      end
      vot_pkg::CMD_COMPACT: begin
        if (c.age <= c.now) begin
          cutoff = c.now - c.age;
          for (int i = 0; i < DEPTH; i++) begin
            if (tbl_valid[i] && (tbl_stat[i] == vot_pkg::STAT_FILLED ||
                tbl_stat[i] == vot_pkg::STAT_CANCELLED) && tbl_ftime[i] < cutoff)
              tbl_valid[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < DEPTH; i++)
      if (tbl_valid[i]) r.total += tbl_pnl[i];
    return r;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: presents the next word at the falling edge, drops start once taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0; cmd <= '0; side <= 1'b0; price_fx <= '0; quantity <= '0;
      resting_ahead <= '0; target_id <= '0; micro_price_fx <= '0; now_ns <= '0;
      age_limit_ns <= '0;
    end else if (start && busy) begin
      // The word was taken at the last rising edge.
      start <= 1'b0;
    end else if (!start && !busy && pending_cmds.size() > 0 &&
                 $urandom_range(99, 0) >= sender_idle_pct) begin
      order_cmd_t c;
      c = pending_cmds.pop_front();
      expected_results.insert(expected_results.size(), apply_order_cmd(c));
      cmd_count[c.cmd]++;
      cmd <= c.cmd; side <= c.side; price_fx <= c.price; quantity <= c.qty;
      resting_ahead <= c.ahead; target_id <= c.target; micro_price_fx <= c.mark;
      now_ns <= c.now; age_limit_ns <= c.age;
      start <= 1'b1;
    end
  end

  // Monitor: checks each done word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      order_res_t e;
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no expected word pending");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (new_id !== e.new_id) begin
          $error("new_id expected %0d actual %0d", e.new_id, new_id); errors++;
        end
        if (ok !== e.ok) begin
          $error("ok expected %0d actual %0d", e.ok, ok); errors++;
        end
        if (total_profit !== e.total) begin
          $error("total_profit expected %0d actual %0d", $signed(e.total),
                 total_profit);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("tb_virtual_order_queue_tracker: errors");
    $finish;
  end

  function automatic logic [46:0] rand47();
    return 47'({$urandom(), $urandom()});
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom(), $urandom()});
  endfunction

  // One word with every field random.
  function automatic order_cmd_t noise_cmd();
    order_cmd_t c;
    c = CMD_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    return c;
  endfunction

  logic [46:0] price_pool[4];
  logic [62:0] clock_ns;

  // A realistic word built on a few shared prices and a rising clock.
  function automatic order_cmd_t market_cmd();
    order_cmd_t c;
    int pick;
    c = noise_cmd();
    pick = $urandom_range(99, 0);
    c.price = price_pool[$urandom_range(3, 0)];
    c.mark = ($urandom_range(3, 0) == 0) ? rand47()
           : price_pool[$urandom_range(3, 0)] + $urandom_range(2000, 0) - 1000;
    c.side = 1'($urandom_range(1, 0));
    clock_ns = clock_ns + $urandom_range(1000, 1);
    c.now = clock_ns;
    c.age = ($urandom_range(4, 0) == 0) ? rand63() : $urandom_range(3000, 0);
    c.ahead = ($urandom_range(2, 0) == 0) ? $urandom() : $urandom_range(3, 0);
    c.qty = ($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(5, 0);
    c.target = next_id - $urandom_range(20, 0);
    if (pick < 35) c.cmd = vot_pkg::CMD_PLACE;
    else if (pick < 45) c.cmd = vot_pkg::CMD_CANCEL;
    else if (pick < 80) c.cmd = vot_pkg::CMD_TRADE;
    else if (pick < 90) c.cmd = vot_pkg::CMD_MARK;
    else if (pick < 97) c.cmd = vot_pkg::CMD_COMPACT;
    else c.cmd = 3'($urandom_range(7, 5));
    return c;
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_results.size() > 0)
      @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    order_cmd_t c;
    errors = 0; results_seen = 0; sender_idle_pct = 0;
    next_id = '0; clock_ns = 63'd1000;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0; tbl_pnl[i] = '0;
    end
    rst = 1'b1;
    price_pool[0] = 47'd10000000000; price_pool[1] = '1;
    price_pool[2] = '0; price_pool[3] = rand47();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, each command, full table, fills and compact cutoffs.
    c = '0; c.cmd = vot_pkg::CMD_PLACE; c.price = '1; c.qty = '1; c.ahead = '0;
    c.side = 1'b0;
    add_pending(c);
    c.side = 1'b1; c.price = '0; add_pending(c);
    c = '0; c.cmd = vot_pkg::CMD_TRADE; c.price = '1; c.side = 1'b0; c.now = 63'd5;
    add_pending(c);
    c.price = '0; c.side = 1'b1; c.now = '1; add_pending(c);
    c = '0; c.cmd = vot_pkg::CMD_MARK; c.mark = '0; add_pending(c);
    c.mark = '1; add_pending(c);
    c = '0; c.cmd = vot_pkg::CMD_PLACE; c.ahead = '1; c.qty = 32'd7; c.price = 47'd100;
    add_pending(c);
    c = '0; c.cmd = vot_pkg::CMD_TRADE; c.price = 47'd100; c.qty = '1; add_pending(c);
    c = '0; c.cmd = vot_pkg::CMD_CANCEL; c.target = 32'd2; add_pending(c);
    add_pending(c);
    c.target = '1; add_pending(c);
    c = '0; c.cmd = vot_pkg::CMD_COMPACT; c.now = 63'd3; c.age = 63'd4; add_pending(c);
    c.now = '1; c.age = '1; add_pending(c);
    c.age = '0; add_pending(c);
    c = '0; c.cmd = 3'd5; add_pending(c);
    c.cmd = 3'd7; c.side = 1'b1; add_pending(c);
    drain();
    // Fill the table past full.
    for (int i = 0; i < DEPTH + 2; i++) begin
      c = noise_cmd(); c.cmd = vot_pkg::CMD_PLACE; add_pending(c);
    end
    drain();
    c = '0; c.cmd = vot_pkg::CMD_COMPACT; c.now = '1; add_pending(c);
    for (int i = 0; i < DEPTH; i++) begin
      c = '0; c.cmd = vot_pkg::CMD_CANCEL; c.target = 32'(i + 3); add_pending(c);
    end
    c = '0; c.cmd = vot_pkg::CMD_COMPACT; c.now = '1; add_pending(c);
    drain();

    // Random phases with differing sender gaps.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1) ? 62 : (ph == 3) ? 7 : 0;
      for (int i = 0; i < 75; i++)
        add_pending(($urandom_range(9, 0) == 0) ? noise_cmd() : market_cmd());
      drain();
    end
    repeat (300) @(posedge clk);

    $display("Ran %0d results: place %0d cancel %0d trade %0d mark %0d compact %0d.",
             results_seen, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3],
             cmd_count[4]);
    if (errors == 0 && expected_results.size() == 0)
      $display("tb_virtual_order_queue_tracker: clean");
    else
      $display("tb_virtual_order_queue_tracker: errors");
    $finish;
  end

endmodule
